### hdl/mmu_pkg.sv
`timescale 1ns / 1ps
// shared constants, command codes and inter-module structs of the matrix multiply unit
// no dependencies

package mmu_pkg;

  localparam int MAX_SIZE = 64;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int DATA_W   = 16;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int ACC_W    = 40;
  localparam int SIZE_W   = 7;
  localparam int CMD_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                     en_a;
    logic                     en_b;
    logic [ADDR_W-1:0]        addr_a;
    logic [ADDR_W-1:0]        addr_b;
    logic signed [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rd_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

### hdl/mmu_store.sv
`timescale 1ns / 1ps
// element stores for matrix a (row major) and matrix b (transposed), with registered read data
// depends on mmu_pkg

module mmu_store (
  input  logic                             clk_i,
  input  mmu_pkg::wr_t                     wr_i,
  input  mmu_pkg::rd_t                     rd_i,
  output logic signed [mmu_pkg::DATA_W-1:0] rd_data_a_o,
  output logic signed [mmu_pkg::DATA_W-1:0] rd_data_b_o
);
  import mmu_pkg::*;

  logic signed [DATA_W-1:0] mem_a [DEPTH];
  logic signed [DATA_W-1:0] mem_b [DEPTH];
  logic signed [DATA_W-1:0] rd_data_a_q;
  logic signed [DATA_W-1:0] rd_data_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en_a) begin
      mem_a[wr_i.addr_a] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_a_q <= mem_a[rd_i.addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en_b) begin
      mem_b[wr_i.addr_b] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_b_q <= mem_b[rd_i.addr_b];
    end
  end

  assign rd_data_a_o = rd_data_a_q;
  assign rd_data_b_o = rd_data_b_q;

endmodule

### hdl/mmu_mac.sv
`timescale 1ns / 1ps
// two-stage multiply-accumulate: registered product, then accumulator with clear on first term
// depends on mmu_pkg

module mmu_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mmu_pkg::tag_t                     tag_i,
  input  logic signed [mmu_pkg::DATA_W-1:0] a_i,
  input  logic signed [mmu_pkg::DATA_W-1:0] b_i,
  output logic signed [mmu_pkg::ACC_W-1:0]  acc_o,
  output logic                              done_o
);
  import mmu_pkg::*;

  tag_t                     tag1_q;
  tag_t                     tag2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     done_q;

  // tag1 lines up with the registered memory data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      done_q <= 1'b0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      done_q <= tag2_q.valid & tag2_q.last;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (tag1_q.valid) begin
      prod_q <= a_i * b_i;
    end
    if (tag2_q.valid) begin
      acc_q <= tag2_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

### hdl/mmu_ctrl.sv
`timescale 1ns / 1ps
// sequencer: input handshake, load writes, dot product read issue and result register
// depends on mmu_pkg

module mmu_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mmu_pkg::SIZE_W-1:0]        n_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mmu_pkg::CMD_W-1:0]         cmd_i,
  input  logic [mmu_pkg::IDX_W-1:0]         row_i,
  input  logic [mmu_pkg::IDX_W-1:0]         col_i,
  input  logic signed [mmu_pkg::DATA_W-1:0] value_i,
  output mmu_pkg::wr_t                      wr_o,
  output mmu_pkg::rd_t                      rd_o,
  output mmu_pkg::tag_t                     tag_o,
  input  logic signed [mmu_pkg::ACC_W-1:0]  acc_i,
  input  logic                              done_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mmu_pkg::IDX_W-1:0]         out_row_o,
  output logic [mmu_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [mmu_pkg::ACC_W-1:0]  product_value_o,
  output logic                              last_o
);
  import mmu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_PUSH
  } state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        row_q;
  logic [IDX_W-1:0]        k_q;
  logic [IDX_W-1:0]        j_q;
  logic                    out_valid_q;
  logic [IDX_W-1:0]        out_row_q;
  logic [IDX_W-1:0]        out_col_q;
  logic signed [ACC_W-1:0] out_value_q;
  logic                    out_last_q;

  logic                    accept;
  logic                    j_last;
  logic                    k_last;
  logic                    slot_free;
  logic                    push;
  logic [SIZE_W-1:0]       n_m1;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign n_m1       = n_i - SIZE_W'(1);
  assign j_last     = ({1'b0, j_q} == n_m1);
  assign k_last     = ({1'b0, k_q} == n_m1);
  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign push       = (state_q == S_PUSH) & slot_free;

  always_comb begin
    wr_o        = '0;
    wr_o.addr_a = {row_i, col_i};
    wr_o.addr_b = {col_i, row_i};
    wr_o.data   = value_i;
    if (accept) begin
      case (cmd_i)
        CMD_LOAD_A: wr_o.en_a = 1'b1;
        CMD_LOAD_B: wr_o.en_b = 1'b1;
        default:    ;
      endcase
    end
  end

  always_comb begin
    rd_o.en     = (state_q == S_ISSUE);
    rd_o.addr_a = {row_q, j_q};
    rd_o.addr_b = {k_q, j_q};
    tag_o.valid = rd_o.en;
    tag_o.first = (j_q == '0);
    tag_o.last  = j_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      k_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !push) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && cmd_i == CMD_COMPUTE && {1'b0, row_i} < n_i) begin
            row_q   <= row_i;
            k_q     <= '0;
            j_q     <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (j_last) begin
            state_q <= S_WAIT;
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        S_WAIT: begin
          if (done_i) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_row_q   <= row_q;
            out_col_q   <= k_q;
            out_value_q <= acc_i;
            out_last_q  <= k_last;
            j_q         <= '0;
            if (k_last) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + IDX_W'(1);
              state_q <= S_ISSUE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_value_q;
  assign last_o          = out_last_q;

endmodule

### hdl/matrix_multiply_unit.sv
`timescale 1ns / 1ps
// Dense square matrix multiply C = A x B on signed Q1.15 elements with Q10.30 results.
// A load of A or B writes one element into its store. A compute of row i streams
// C[i][0..n-1]: each product element is one dot product of n terms through a single
// multiply-accumulate unit fed by one read port per element store, followed by
// pipeline drain and result handoff.
// A result held in the output register does not block a following load.
// depends on mmu_pkg, mmu_store, mmu_mac, mmu_ctrl

module matrix_multiply_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mmu_pkg::SIZE_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mmu_pkg::CMD_W-1:0]         cmd_i,
  input  logic [mmu_pkg::IDX_W-1:0]         row_i,
  input  logic [mmu_pkg::IDX_W-1:0]         col_i,
  input  logic signed [mmu_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mmu_pkg::IDX_W-1:0]         out_row_o,
  output logic [mmu_pkg::IDX_W-1:0]         out_col_o,
  output logic signed [mmu_pkg::ACC_W-1:0]  product_value_o,
  output logic                              last_o
);
  import mmu_pkg::*;

  logic [SIZE_W-1:0]        size_q;
  logic [SIZE_W-1:0]        n_eff;
  wr_t                      wr;
  rd_t                      rd;
  tag_t                     tag;
  logic signed [DATA_W-1:0] rd_data_a;
  logic signed [DATA_W-1:0] rd_data_b;
  logic signed [ACC_W-1:0]  acc;
  logic                     done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_W'(MAX_SIZE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      size_q <= cfg_data_i;
    end
  end

  // clamp to 1 .. MAX_SIZE
  always_comb begin
    if (size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MAX_SIZE)) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = size_q;
    end
  end

  mmu_store u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_i        (rd),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  mmu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag),
    .a_i    (rd_data_a),
    .b_i    (rd_data_b),
    .acc_o  (acc),
    .done_o (done)
  );

  mmu_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .n_i             (n_eff),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .wr_o            (wr),
    .rd_o            (rd),
    .tag_o           (tag),
    .acc_i           (acc),
    .done_i          (done),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule
